// ----- design/bcec_pkg.sv -----
// Shared types and constants for the button click event classifier.
// Used by the item and register write interfaces, the register block, the core and the top level.
package bcec_pkg;

  localparam int TimerW = 16;
  localparam int CmdW   = 2;
  localparam int RegIdxW = 3;
  localparam int RegDataW = 16;

  // Command codes of an input item
  localparam logic [CmdW-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CmdW-1:0] CMD_TICK   = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CmdW-1:0] CMD_NOP    = 2'd3;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_KEY_ACTIVE_HIGH = 3'd0;
  localparam logic [RegIdxW-1:0] REG_HOLD_LIMIT      = 3'd1;
  localparam logic [RegIdxW-1:0] REG_LONG_LIMIT      = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DOUBLE_WINDOW   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SINGLE_TIMEOUT  = 3'd4;

  // Register reset values
  localparam logic [TimerW-1:0] HOLD_LIMIT_RST     = 16'd2000;
  localparam logic [TimerW-1:0] LONG_LIMIT_RST     = 16'd1500;
  localparam logic [TimerW-1:0] DOUBLE_WINDOW_RST  = 16'd1200;
  localparam logic [TimerW-1:0] SINGLE_TIMEOUT_RST = 16'd250;

  localparam logic [TimerW-1:0] TIMER_MAX = 16'hFFFF;

  typedef struct packed {
    logic              key_active_high;
    logic [TimerW-1:0] hold_limit_ms;
    logic [TimerW-1:0] long_limit_ms;
    logic [TimerW-1:0] double_window_ms;
    logic [TimerW-1:0] single_timeout_ms;
  } cfg_t;

endpackage

// ----- design/bcec_intf.sv -----
// Valid/ready channel interfaces: input items, result items and register writes.
// Depends on bcec_pkg for field widths.
interface bcec_item_if;
  import bcec_pkg::*;
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic            key_level;
  modport source (output valid, cmd, key_level, input ready);
  modport sink   (input valid, cmd, key_level, output ready);
endinterface

interface bcec_result_if;
  logic valid;
  logic ready;
  logic short_pressed;
  logic double_pressed;
  logic long_pressed;
  logic holding;
  modport source (output valid, short_pressed, double_pressed, long_pressed, holding,
                  input ready);
  modport sink   (input valid, short_pressed, double_pressed, long_pressed, holding,
                  output ready);
endinterface

interface bcec_cfg_if;
  import bcec_pkg::*;
  logic                valid;
  logic                ready;
  logic [RegIdxW-1:0]  index;
  logic [RegDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/bcec_cfg_regs.sv -----
// Configuration register file of the classifier.
// Depends on bcec_pkg and the bcec_cfg_if interface.
module bcec_cfg_regs
  import bcec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bcec_cfg_if.sink    cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  // Write the addressed register; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.key_active_high   <= 1'b0;
      regs.hold_limit_ms     <= HOLD_LIMIT_RST;
      regs.long_limit_ms     <= LONG_LIMIT_RST;
      regs.double_window_ms  <= DOUBLE_WINDOW_RST;
      regs.single_timeout_ms <= SINGLE_TIMEOUT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KEY_ACTIVE_HIGH: regs.key_active_high   <= cfg.data[0];
        REG_HOLD_LIMIT:      regs.hold_limit_ms     <= cfg.data;
        REG_LONG_LIMIT:      regs.long_limit_ms     <= cfg.data;
        REG_DOUBLE_WINDOW:   regs.double_window_ms  <= cfg.data;
        REG_SINGLE_TIMEOUT:  regs.single_timeout_ms <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/bcec_core.sv -----
// Press tracking state, timers and sticky event flags, with the result register.
// Depends on bcec_pkg and the item and result interfaces.
module bcec_core
  import bcec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         regs,
  bcec_item_if.sink    item_in,
  bcec_result_if.source result_out
);

  logic              is_down, is_down_next;
  logic [TimerW-1:0] down_time, down_time_next;
  logic [TimerW-1:0] gap_time, gap_time_next;
  logic              gap_running, gap_running_next;
  logic [1:0]        release_count, release_count_next;
  logic              flag_short, flag_short_next;
  logic              flag_double, flag_double_next;
  logic              flag_long, flag_long_next;
  logic              flag_hold, flag_hold_next;
  logic              res_valid;
  logic              accept;
  logic              pressed;
  logic [TimerW-1:0] gap_inc;

  // Take a new item whenever the result slot is empty or being drained
  assign item_in.ready = !res_valid || result_out.ready;
  assign accept        = item_in.valid && item_in.ready;

  assign pressed = (item_in.key_level == regs.key_active_high);
  assign gap_inc = (gap_time == TIMER_MAX) ? gap_time : gap_time + 1'b1;

  // Next state for one item
  always_comb begin
    is_down_next       = is_down;
    down_time_next     = down_time;
    gap_time_next      = gap_time;
    gap_running_next   = gap_running;
    release_count_next = release_count;
    flag_short_next    = flag_short;
    flag_double_next   = flag_double;
    flag_long_next     = flag_long;
    flag_hold_next     = flag_hold;
    unique case (item_in.cmd)
      CMD_SAMPLE: begin
        if (pressed) begin
          if (!is_down) begin
            is_down_next   = 1'b1;
            down_time_next = '0;
          end else if (down_time >= regs.hold_limit_ms) begin
            flag_hold_next = 1'b1;
          end
        end else if (is_down) begin
          is_down_next   = 1'b0;
          flag_hold_next = 1'b0;
          priority if (down_time >= regs.long_limit_ms) begin
            flag_short_next  = 1'b0;
            flag_double_next = 1'b0;
            flag_long_next   = 1'b1;
          end else if (release_count == 2'd1 && gap_time <= regs.double_window_ms) begin
            release_count_next = '0;
            gap_running_next   = 1'b0;
            flag_short_next    = 1'b0;
            flag_double_next   = 1'b1;
            flag_long_next     = 1'b0;
          end else begin
            gap_time_next    = '0;
            gap_running_next = 1'b1;
            if (release_count != 2'd3) begin
              release_count_next = release_count + 2'd1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (is_down && down_time != TIMER_MAX) begin
          down_time_next = down_time + 1'b1;
        end
        if (gap_running) begin
          gap_time_next = gap_inc;
          if (gap_inc >= regs.single_timeout_ms) begin
            gap_running_next   = 1'b0;
            release_count_next = '0;
            flag_short_next    = 1'b1;
            flag_double_next   = 1'b0;
            flag_long_next     = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        flag_short_next  = 1'b0;
        flag_double_next = 1'b0;
        flag_long_next   = 1'b0;
      end
      CMD_NOP: ;
      default: ;
    endcase
  end

  // Update state on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      is_down       <= 1'b0;
      down_time     <= '0;
      gap_time      <= '0;
      gap_running   <= 1'b0;
      release_count <= '0;
      flag_short    <= 1'b0;
      flag_double   <= 1'b0;
      flag_long     <= 1'b0;
      flag_hold     <= 1'b0;
    end else if (accept) begin
      is_down       <= is_down_next;
      down_time     <= down_time_next;
      gap_time      <= gap_time_next;
      gap_running   <= gap_running_next;
      release_count <= release_count_next;
      flag_short    <= flag_short_next;
      flag_double   <= flag_double_next;
      flag_long     <= flag_long_next;
      flag_hold     <= flag_hold_next;
    end
  end

  // Hold the result until taken; the flag registers are the payload
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_in.ready) begin
      res_valid <= item_in.valid;
    end
  end

  assign result_out.valid          = res_valid;
  assign result_out.short_pressed  = flag_short;
  assign result_out.double_pressed = flag_double;
  assign result_out.long_pressed   = flag_long;
  assign result_out.holding        = flag_hold;

  // A running gap timer always follows a counted short release
  a_gap_has_release: assert property (@(posedge clk) disable iff (rst)
    gap_running |-> release_count != 2'd0)
    else $error("gap timer running with no release counted");

  // Holding only while the key is down
  a_hold_needs_down: assert property (@(posedge clk) disable iff (rst)
    flag_hold |-> is_down)
    else $error("holding flag set while key is released");

  // Click events exclude each other
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    $onehot0({flag_short, flag_double, flag_long}))
    else $error("more than one click event flag set");

  // Every accepted item yields a result in the next cycle
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted item produced no result");

endmodule

// ----- design/button_click_event_classifier_top.sv -----
// Top level of the push button click classifier: register block and core.
// Depends on bcec_pkg, the channel interfaces, bcec_cfg_regs and bcec_core.
//
//   port        dir   role                 payload
//   clk         in    clock                -
//   rst         in    sync reset, high     -
//   item_in     sink  sample/tick/clear    cmd, key_level
//   result_out  src   flags after update   short/double/long_pressed, holding
//   cfg         sink  register write       index, data
//
// One item per cycle unless a result waits untaken; each accepted item gives its result in the next cycle.
// The state registers and the flag/result register are the only stage.
// item_in.ready drops only while a result waits and result_out.ready is low.
// Reset clears all state and loads the register defaults; cfg is always ready.
module button_click_event_classifier_top
  import bcec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  bcec_item_if.sink     item_in,
  bcec_result_if.source result_out,
  bcec_cfg_if.sink      cfg
);

  cfg_t regs;

  bcec_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bcec_core u_core (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_in    (item_in),
    .result_out (result_out)
  );

endmodule
